FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the max-tracking FIFO modules.
// Each expects clk and rst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared constants, codes and control structs of the max-tracking FIFO.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int DATA_W      = 32;

  // Input command codes; the unused code acts as a query
  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DEQ_EMPTY = 2'd1,
    ST_ENQ_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MV_RD,
    S_MV_WR,
    S_POP_RD,
    S_POP_WR,
    S_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;   // latch accepted item, clear per-item result
    logic push_in;     // enqueue onto input stack
    logic rej_full;    // flag enqueue on full
    logic rej_empty;   // flag dequeue on empty
    logic mv_wr;       // push read element onto output stack
    logic pop_wr;      // complete the pop
    logic load_out;    // load result register
  } mtf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_enq;
    logic is_deq;
    logic full;
    logic empty;
    logic in_last;     // input stack holds exactly one element
    logic out_empty;
    logic out_slot_free;
  } mtf_sts_t;

endpackage

FILE: sv/mtf_ram.sv
// ----------------------------------------------------------------------------
// mtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtf_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/mtf_dp.sv
// ----------------------------------------------------------------------------
// mtf_dp
// Datapath: stack counts, top-of-stack maxima, stack RAMs, result register.
// ----------------------------------------------------------------------------
module mtf_dp
  import mtf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mtf_cmd_t                 cmd,
  output mtf_sts_t                 sts,
  input  logic [1:0]               in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic signed [DATA_W-1:0] out_current_max,
  output logic                     out_queue_empty,
  output logic [1:0]               out_status
);

  `include "assert_macros.svh"

  // item and per-item result
  logic [1:0]               cmd_r;
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] removed_r;
  status_t                  status_r;

  // stack state
  logic [CNT_W-1:0]         in_cnt_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic signed [DATA_W-1:0] in_top_max_r;
  logic signed [DATA_W-1:0] out_top_max_r;

  // result register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_removed_r;
  logic signed [DATA_W-1:0] out_max_r;
  logic                     out_empty_r;
  status_t                  out_status_r;

  logic [CNT_W-1:0]         in_cnt_dec;
  logic [CNT_W-1:0]         out_cnt_dec;
  logic [CNT_W-1:0]         out_cnt_dec2;
  logic [CNT_W:0]           total;
  logic signed [DATA_W-1:0] push_max;
  logic signed [DATA_W-1:0] mv_data;
  logic signed [DATA_W-1:0] mv_max;
  logic signed [DATA_W-1:0] pop_val;
  logic signed [DATA_W-1:0] pop_max;
  logic signed [DATA_W-1:0] cur_max;
  logic                     q_empty;

  assign in_cnt_dec   = in_cnt_r - CNT_W'(1);
  assign out_cnt_dec  = out_cnt_r - CNT_W'(1);
  assign out_cnt_dec2 = out_cnt_r - CNT_W'(2);
  assign total        = {1'b0, in_cnt_r} + {1'b0, out_cnt_r};

  // running max for a push: first element sets it
  assign push_max = (in_cnt_r == '0 || value_r > in_top_max_r) ? value_r : in_top_max_r;
  assign mv_max   = (out_cnt_r == '0 || mv_data > out_top_max_r) ? mv_data : out_top_max_r;

  // stack RAMs; the input stack's maxima live only in the top register
  mtf_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_in_val (
    .clk   (clk),
    .we    (cmd.push_in),
    .waddr (in_cnt_r[ADDR_W-1:0]),
    .wdata (value_r),
    .raddr (in_cnt_dec[ADDR_W-1:0]),
    .rdata (mv_data)
  );

  mtf_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_out_val (
    .clk   (clk),
    .we    (cmd.mv_wr),
    .waddr (out_cnt_r[ADDR_W-1:0]),
    .wdata (mv_data),
    .raddr (out_cnt_dec[ADDR_W-1:0]),
    .rdata (pop_val)
  );

  mtf_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_out_max (
    .clk   (clk),
    .we    (cmd.mv_wr),
    .waddr (out_cnt_r[ADDR_W-1:0]),
    .wdata (mv_max),
    .raddr (out_cnt_dec2[ADDR_W-1:0]),
    .rdata (pop_max)
  );

  // item latch and per-item result
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r     <= in_command;
      value_r   <= in_value;
      removed_r <= '0;
      status_r  <= ST_OK;
    end else begin
      if (cmd.rej_full) begin
        status_r <= ST_ENQ_FULL;
      end
      if (cmd.rej_empty) begin
        status_r <= ST_DEQ_EMPTY;
      end
      if (cmd.pop_wr) begin
        removed_r <= pop_val;
      end
    end
  end

  // stack counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
    end else begin
      if (cmd.push_in) begin
        in_cnt_r <= in_cnt_r + CNT_W'(1);
      end
      if (cmd.mv_wr) begin
        in_cnt_r  <= in_cnt_dec;
        out_cnt_r <= out_cnt_r + CNT_W'(1);
      end
      if (cmd.pop_wr) begin
        out_cnt_r <= out_cnt_dec;
      end
    end
  end

  // top-of-stack maxima; only meaningful while the count is nonzero
  always_ff @(posedge clk) begin
    if (cmd.push_in) begin
      in_top_max_r <= push_max;
    end
    if (cmd.mv_wr) begin
      out_top_max_r <= mv_max;
    end
    if (cmd.pop_wr) begin
      out_top_max_r <= pop_max;
    end
  end

  // queue maximum from the two stack tops
  always_comb begin
    if (in_cnt_r != '0 && out_cnt_r != '0) begin
      cur_max = (in_top_max_r > out_top_max_r) ? in_top_max_r : out_top_max_r;
    end else if (in_cnt_r != '0) begin
      cur_max = in_top_max_r;
    end else if (out_cnt_r != '0) begin
      cur_max = out_top_max_r;
    end else begin
      cur_max = '0;
    end
  end

  assign q_empty = (in_cnt_r == '0) && (out_cnt_r == '0);

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_removed_r <= removed_r;
      out_max_r     <= cur_max;
      out_empty_r   <= q_empty;
      out_status_r  <= status_r;
    end
  end

  // status to controller
  assign sts.is_enq        = (cmd_r == OP_ENQ);
  assign sts.is_deq        = (cmd_r == OP_DEQ);
  assign sts.full          = (total >= (CNT_W+1)'(QUEUE_DEPTH));
  assign sts.empty         = q_empty;
  assign sts.in_last       = (in_cnt_r == CNT_W'(1));
  assign sts.out_empty     = (out_cnt_r == '0);
  assign sts.out_slot_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_current_max   = out_max_r;
  assign out_queue_empty   = out_empty_r;
  assign out_status        = out_status_r;

  // never more elements than the queue depth
  `ASSERT_ALWAYS(a_cap, total <= (CNT_W+1)'(QUEUE_DEPTH))
  // a pop removes exactly one element from the output stack
  `ASSERT_NEXT(a_pop, cmd.pop_wr, out_cnt_r == CNT_W'($past(out_cnt_r) - CNT_W'(1)))
  // a loaded result is presented next cycle
  `ASSERT_NEXT(a_load, cmd.load_out, out_valid_r)

endmodule

FILE: sv/mtf_ctrl.sv
// ----------------------------------------------------------------------------
// mtf_ctrl
// Sequencer: steps one item through execute, move, pop and respond.
// ----------------------------------------------------------------------------
module mtf_ctrl
  import mtf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mtf_sts_t sts,
  output mtf_cmd_t cmd
);

  `include "assert_macros.svh"

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  // accept while idle, or while the result of the last item is handed off
  assign in_ready = (state_r == S_IDLE) || (state_r == S_RESP && sts.out_slot_free);
  assign in_fire  = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_deq && !sts.empty) begin
          state_nxt = sts.out_empty ? S_MV_RD : S_POP_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_MV_RD:  state_nxt = S_MV_WR;
      S_MV_WR:  state_nxt = sts.in_last ? S_POP_RD : S_MV_RD;
      S_POP_RD: state_nxt = S_POP_WR;
      S_POP_WR: state_nxt = S_RESP;
      S_RESP: begin
        if (sts.out_slot_free) begin
          state_nxt = in_fire ? S_EXEC : S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // command outputs; read steps only wait out the RAM read latency
  always_comb begin
    cmd           = '0;
    cmd.load_item = in_fire;
    case (state_r)
      S_EXEC: begin
        cmd.push_in   = sts.is_enq && !sts.full;
        cmd.rej_full  = sts.is_enq && sts.full;
        cmd.rej_empty = sts.is_deq && sts.empty;
      end
      S_MV_WR:  cmd.mv_wr    = 1'b1;
      S_POP_WR: cmd.pop_wr   = 1'b1;
      S_RESP:   cmd.load_out = sts.out_slot_free;
      default: begin
      end
    endcase
  end

  // no new item while stacks are being reorganized
  `ASSERT_IMPL(a_busy, state_r == S_MV_RD || state_r == S_MV_WR || state_r == S_POP_WR, !in_ready)
  // a move step always finds an element in the queue
  `ASSERT_IMPL(a_mv, state_r == S_MV_WR, !sts.empty)

endmodule

FILE: sv/max_tracking_fifo.sv
// ----------------------------------------------------------------------------
// max_tracking_fifo
// Queue of signed 32-bit values reporting the maximum of its contents.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries in_command and in_value:
//   enqueue, dequeue oldest, or query. Every accepted item gives one result
//   on the output channel (out_valid/out_ready): the dequeued value, the
//   queue maximum after the operation (0 when empty), an empty flag and a
//   status (ok, dequeue on empty, enqueue on full).
//   Steps from acceptance to out_valid: enqueue, query and rejected operations
//   pass through execute and respond; a dequeue served from the output stack
//   adds a pop read and a pop write step; a dequeue on an empty output stack
//   first moves each element of the input stack across, with a read and a
//   write step per element through the input stack RAM's registered read port.
//   Overlap: the next item is accepted during the respond step of the last one
//   once the output register is free; the moves above add steps, and each
//   element is moved across only once.
//   Reset: both stacks are emptied by clearing their counts; no memory
//   clearing pass, the block is ready right after reset.
//   Stall: a result waits in the output register; the block holds the next
//   item in its respond step until the receiver takes the result.
// ----------------------------------------------------------------------------
module max_tracking_fifo
  import mtf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic signed [DATA_W-1:0] out_current_max,
  output logic                     out_queue_empty,
  output logic [1:0]               out_status
);

  mtf_cmd_t cmd;
  mtf_sts_t sts;

  // sequencer
  mtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stacks and result register
  mtf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_command        (in_command),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_current_max   (out_current_max),
    .out_queue_empty   (out_queue_empty),
    .out_status        (out_status)
  );

endmodule

FILE: bench/tb_max_tracking_fifo.sv
// ----------------------------------------------------------------------------
// tb_max_tracking_fifo
// Self-checking bench for the max-tracking FIFO. Commands go in on the
// valid/ready input channel. Each accepted transfer is run against a plain
// queue image of the contents, and the expected result is put in line. The
// checker compares every result transfer field by field. Directed cases come
// first (empty, extremes, full, deep stack move), then random mixed traffic
// and fill/drain bursts, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_max_tracking_fifo
  import mtf_pkg::*;
();

  // unused command code, behaves as a query
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct {
    logic signed [DATA_W-1:0] removed;
    logic signed [DATA_W-1:0] peak;
    logic                     empty;
    status_t                  status;
  } queue_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_command = OP_QUERY;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_removed_value;
  logic signed [DATA_W-1:0] out_current_max;
  logic                     out_queue_empty;
  logic [1:0]               out_status;

  logic signed [DATA_W-1:0] queue_image[$];
  queue_result_t            pending_results[$];
  int                       error_count = 0;
  int                       in_gap_max = 3;
  int                       out_stall_max = 3;
  int                       stall_left = 0;

  max_tracking_fifo i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_current_max   (out_current_max),
    .out_queue_empty   (out_queue_empty),
    .out_status        (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial begin
    #3000000;
    $display("tb_max_tracking_fifo: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Apply one command to the queue image and work out the result
  function automatic queue_result_t apply_queue_op(input logic [1:0] cmd,
                                                   input logic signed [DATA_W-1:0] val);
    queue_result_t res;
    res.removed = '0;
    res.peak    = '0;
    res.status  = ST_OK;
    case (cmd)
      OP_ENQ: begin
        if (queue_image.size() >= QUEUE_DEPTH) res.status = ST_ENQ_FULL;
        else queue_image.push_back(val);
      end
      OP_DEQ: begin
        if (queue_image.size() == 0) res.status = ST_DEQ_EMPTY;
        else res.removed = queue_image.pop_front();
      end
      default: ;  // query and spare code leave the contents alone
    endcase
    res.empty = (queue_image.size() == 0);
    foreach (queue_image[i]) begin
      if (i == 0 || queue_image[i] > res.peak) res.peak = queue_image[i];
    end
    return res;
  endfunction

  // Send one item; entered and left at a rising edge
  task automatic send_item(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_queue_op(cmd, val));
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    queue_result_t exp;
    int gap;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        exp = pending_results.pop_front();
        if (out_removed_value !== exp.removed)
          report_mismatch($sformatf("removed_value got %0d exp %0d",
                                    out_removed_value, exp.removed));
        if (out_current_max !== exp.peak)
          report_mismatch($sformatf("current_max got %0d exp %0d",
                                    out_current_max, exp.peak));
        if (out_queue_empty !== exp.empty)
          report_mismatch($sformatf("queue_empty got %b exp %b",
                                    out_queue_empty, exp.empty));
        if (out_status !== exp.status)
          report_mismatch($sformatf("status got %0d exp %0d", out_status, exp.status));
      end
      // receiver stall before the next transfer
      gap = $urandom_range(0, out_stall_max);
      if (gap > 0) begin
        out_ready  <= 1'b0;
        stall_left <= gap - 1;
      end
    end else if (!out_ready) begin
      if (stall_left == 0) out_ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $signed($urandom_range(0, 8)) - 4;  // ties and near-zero
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_command(input int enq_pct, input int deq_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_pct) return OP_ENQ;
    if (r < enq_pct + deq_pct) return OP_DEQ;
    return ($urandom_range(0, 3) == 0) ? CMD_SPARE : OP_QUERY;
  endfunction

  // Random gap setting for a stretch of traffic, often no idling at all
  task automatic pick_idling();
    in_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 3;
    out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
  endtask

  // Operations on an empty queue, single most-negative element
  task automatic test_empty_queue();
    send_item(OP_DEQ, 32'sd5);
    send_item(OP_QUERY, 32'sh7FFF_FFFF);
    send_item(CMD_SPARE, -32'sd1);
    send_item(OP_ENQ, 32'sh8000_0000);
    send_item(OP_DEQ, '0);
  endtask

  // Fill to full with extremes, reject, then a dequeue that moves all across
  task automatic test_full_and_move();
    logic signed [DATA_W-1:0] fill_values[16] = '{
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sh7FFF_FFFE,
      32'sh8000_0001, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_FFFE, -32'sd2,
      32'sd100, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh4000_0000, 32'sd3};
    foreach (fill_values[i]) send_item(OP_ENQ, fill_values[i]);
    send_item(OP_ENQ, 32'sh7FFF_FFFF);
    send_item(CMD_SPARE, '0);
    send_item(OP_DEQ, '0);
    send_item(OP_DEQ, '0);
  endtask

  // Balanced random traffic
  task automatic test_mixed_random();
    for (int i = 0; i < 500; i++) begin
      if (i % 50 == 0) pick_idling();
      send_item(pick_command(45, 40), pick_value());
    end
  endtask

  // Enqueue-heavy and dequeue-heavy bursts to hit full and empty often
  task automatic test_fill_drain_bursts();
    int sent;
    int burst;
    sent = 0;
    while (sent < 725) begin
      pick_idling();
      burst = $urandom_range(10, 40);
      for (int i = 0; i < burst; i++) begin
        if ((sent / 30) % 2 == 0) send_item(pick_command(80, 15), pick_value());
        else send_item(pick_command(15, 80), pick_value());
        sent++;
      end
    end
  endtask

  // Wait out the remaining results, then report
  task automatic finish_run();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_max_tracking_fifo: done, clean");
    end else begin
      $display("tb_max_tracking_fifo: done, errors");
    end
    $finish;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_full_and_move();
    test_mixed_random();
    test_fill_drain_bursts();
    finish_run();
  end

endmodule
